### sv/char_lcd_nibble_writer_macros.svh
// assertion macros for the character lcd nibble writer
`ifndef CHAR_LCD_NIBBLE_WRITER_MACROS_SVH
`define CHAR_LCD_NIBBLE_WRITER_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked on clk with arst_n low as reset
`define CLNW_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("clnw assertion failed");
// next-cycle implication
`define CLNW_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("clnw assertion failed");
`else
`define CLNW_ASSERT_SAME(lbl, ante, cons)
`define CLNW_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### sv/clnw_pkg.sv
// types, constants and microprogram of the character lcd nibble writer
package clnw_pkg;

	localparam int NUM_W     = 31;
	localparam int UPC_W     = 5;
	localparam int BIT_CNT_W = 5;

	// request kinds
	localparam logic [2:0] KIND_INIT   = 3'd0;
	localparam logic [2:0] KIND_HALF   = 3'd1;
	localparam logic [2:0] KIND_CMD    = 3'd2;
	localparam logic [2:0] KIND_DATA   = 3'd3;
	localparam logic [2:0] KIND_CURSOR = 3'd4;
	localparam logic [2:0] KIND_NUMBER = 3'd5;

	// register map
	localparam logic [2:0] ADDR_LINE_LENGTH  = 3'd0;
	localparam logic [6:0] LINE_LENGTH_RESET = 7'd16;

	localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
	localparam logic [3:0] DIGIT_HI_NIB  = 4'h3;

	// microprogram entry points
	localparam logic [UPC_W-1:0] UA_INIT   = 5'd0;
	localparam logic [UPC_W-1:0] UA_HALF   = 5'd13;
	localparam logic [UPC_W-1:0] UA_BYTE   = 5'd14;
	localparam logic [UPC_W-1:0] UA_NUMBER = 5'd16;
	localparam logic [UPC_W-1:0] UA_DIGIT  = 5'd17;
	localparam logic [UPC_W-1:0] UA_LAST   = 5'd18;

	typedef struct packed {
		logic [2:0]       kind;
		logic [7:0]       byte_value;
		logic [2:0]       line_number;
		logic [7:0]       column;
		logic [NUM_W-1:0] number_value;
	} req_t;

	typedef struct packed {
		logic       register_select;
		logic [3:0] nibble;
		logic       last;
	} nib_t;

	typedef enum logic [2:0] {
		OP_CONST    = 3'd0,
		OP_BYTE_HI  = 3'd1,
		OP_BYTE_LO  = 3'd2,
		OP_DABBLE   = 3'd3,
		OP_DIGIT_HI = 3'd4,
		OP_DIGIT_LO = 3'd5
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [3:0]       konst;
		logic             fin;
		logic [UPC_W-1:0] target;
	} cw_t;

	function automatic cw_t ucode(input logic [UPC_W-1:0] a);
		cw_t cw;
		case (a)
			5'd0:    cw = '{OP_CONST, 4'h3, 1'b0, UA_INIT};
			5'd1:    cw = '{OP_CONST, 4'h3, 1'b0, UA_INIT};
			5'd2:    cw = '{OP_CONST, 4'h2, 1'b0, UA_INIT};
			5'd3:    cw = '{OP_CONST, 4'h2, 1'b0, UA_INIT};
			5'd4:    cw = '{OP_CONST, 4'h8, 1'b0, UA_INIT};
			5'd5:    cw = '{OP_CONST, 4'h0, 1'b0, UA_INIT};
			5'd6:    cw = '{OP_CONST, 4'hC, 1'b0, UA_INIT};
			5'd7:    cw = '{OP_CONST, 4'h0, 1'b0, UA_INIT};
			5'd8:    cw = '{OP_CONST, 4'h1, 1'b0, UA_INIT};
			5'd9:    cw = '{OP_CONST, 4'h0, 1'b0, UA_INIT};
			5'd10:   cw = '{OP_CONST, 4'h6, 1'b0, UA_INIT};
			5'd11:   cw = '{OP_CONST, 4'h8, 1'b0, UA_INIT};
			5'd12:   cw = '{OP_CONST, 4'h0, 1'b1, UA_INIT};
			5'd13:   cw = '{OP_BYTE_HI, 4'h0, 1'b1, UA_INIT};
			5'd14:   cw = '{OP_BYTE_HI, 4'h0, 1'b0, UA_INIT};
			5'd15:   cw = '{OP_BYTE_LO, 4'h0, 1'b1, UA_INIT};
			5'd16:   cw = '{OP_DABBLE, 4'h0, 1'b0, UA_INIT};
			5'd17:   cw = '{OP_DIGIT_HI, 4'h0, 1'b0, UA_INIT};
			5'd18:   cw = '{OP_DIGIT_LO, 4'h0, 1'b0, UA_DIGIT};
			default: cw = '{OP_CONST, 4'h0, 1'b1, UA_INIT};
		endcase
		return cw;
	endfunction

	// ten to the power k, valid for k up to 19
	function automatic logic [63:0] pow10(input int k);
		logic [63:0] p;
		p = 64'd1;
		for (int i = 0; i < k; i++) begin
			p = p * 64'd10;
		end
		return p;
	endfunction

endpackage

### sv/char_lcd_nibble_writer.sv
// character lcd 4-bit nibble writer, microcoded sequencer with apb config
// the request beat starts the sequencer; nibbles leave through the output register, one per cycle while not stalled
// init gives 13 nibbles, command/data/cursor 2, half command 1, all at one per cycle while not stalled
// number: double-dabble conversion of all 31 bits, then two nibbles per digit
// req_stall holds off a new request until the last nibble of the current one is emitted
// reset: arst_n clears sequencer, output valid and line_length (back to 16)
`include "char_lcd_nibble_writer_macros.svh"

module char_lcd_nibble_writer #(
	parameter int MAX_DIGITS = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	// request channel
	input  logic              req_valid,
	output logic              req_stall,
	input  clnw_pkg::req_t    req,
	// nibble channel
	output logic              nib_valid,
	input  logic              nib_stall,
	output clnw_pkg::nib_t    nib,
	// apb config port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int DIG_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int BCD_W = 4 * MAX_DIGITS;

	// sequencer state, one-hot
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t                          state_q;
	logic [clnw_pkg::UPC_W-1:0]      upc_q;
	logic [7:0]                      byte_q;       // byte for hi/lo steps
	logic                            rs_q;         // register select for byte steps
	logic [clnw_pkg::NUM_W-1:0]      num_q;        // number being shifted into bcd
	logic [BCD_W-1:0]                bcd_q;        // packed bcd digits
	logic [clnw_pkg::BIT_CNT_W-1:0]  bit_cnt_q;    // dabble shift count
	logic [DIG_W-1:0]                dig_idx_q;    // digit being printed
	logic [6:0]                      line_length_q;
	logic                            nib_valid_q;
	clnw_pkg::nib_t                  nib_q;

	clnw_pkg::cw_t                   cw;
	logic                            is_emit;
	logic                            out_free;
	logic                            step_go;
	logic                            emit_go;
	logic                            emit_last;
	clnw_pkg::nib_t                  emit_nib;
	logic                            req_take;
	logic                            kind_ok;
	logic [clnw_pkg::UPC_W-1:0]      entry;
	logic [7:0]                      base;
	logic [7:0]                      cur_addr;
	logic [7:0]                      req_byte;
	logic [DIG_W-1:0]                lead;
	logic [BCD_W-1:0]                bcd_adj;
	logic [3:0]                      digit;
	logic                            cfg_wr;

	// ---------------------------------------------------------------
	// apb register: line_length, writes complete in the access cycle
	// ---------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == clnw_pkg::ADDR_LINE_LENGTH);

	always_comb begin
		prdata = 32'd0;
		if (paddr == clnw_pkg::ADDR_LINE_LENGTH) begin
			prdata = {25'd0, line_length_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q <= clnw_pkg::LINE_LENGTH_RESET;
		end else if (cfg_wr) begin
			line_length_q <= pwdata[6:0];
		end
	end

	// ---------------------------------------------------------------
	// request decode: entry point, byte to send, leading digit index
	// ---------------------------------------------------------------
	assign req_stall = (state_q != ST_IDLE);
	assign req_take  = req_valid && !req_stall;

	always_comb begin
		kind_ok = 1'b1;
		entry   = clnw_pkg::UA_INIT;
		case (req.kind)
			clnw_pkg::KIND_INIT:   entry = clnw_pkg::UA_INIT;
			clnw_pkg::KIND_HALF:   entry = clnw_pkg::UA_HALF;
			clnw_pkg::KIND_CMD:    entry = clnw_pkg::UA_BYTE;
			clnw_pkg::KIND_DATA:   entry = clnw_pkg::UA_BYTE;
			clnw_pkg::KIND_CURSOR: entry = clnw_pkg::UA_BYTE;
			clnw_pkg::KIND_NUMBER: entry = clnw_pkg::UA_NUMBER;
			default:               kind_ok = 1'b0; // unused kinds give no beat
		endcase
	end

	// line base address, column added only within the line length
	always_comb begin
		case (req.line_number)
			3'd1:    base = 8'h40;
			3'd2:    base = 8'h10;
			3'd3:    base = 8'h50;
			default: base = 8'h00;
		endcase
		cur_addr = base;
		if (req.column <= {1'b0, line_length_q}) begin
			cur_addr = base + req.column;
		end
		if (req.kind == clnw_pkg::KIND_CURSOR) begin
			req_byte = clnw_pkg::CMD_SET_DDRAM | cur_addr;
		end else begin
			req_byte = req.byte_value;
		end
	end

	// most significant digit to print: highest k with value >= 10^k
	always_comb begin
		lead = '0;
		for (int k = 1; k < MAX_DIGITS; k++) begin
			if ({33'd0, req.number_value} >= clnw_pkg::pow10(k)) begin
				lead = DIG_W'(k);
			end
		end
	end

	// ---------------------------------------------------------------
	// microcode fetch and datapath control
	// ---------------------------------------------------------------
	assign cw       = clnw_pkg::ucode(upc_q);
	assign is_emit  = (cw.op != clnw_pkg::OP_DABBLE);
	assign out_free = !nib_valid_q || !nib_stall;
	assign step_go  = (state_q == ST_RUN) &&
		(is_emit ? out_free : (bit_cnt_q == clnw_pkg::BIT_CNT_W'(clnw_pkg::NUM_W - 1)));
	assign emit_go  = step_go && is_emit;

	assign digit     = bcd_q[dig_idx_q * 4 +: 4];
	assign emit_last = cw.fin || ((cw.op == clnw_pkg::OP_DIGIT_LO) && (dig_idx_q == '0));

	always_comb begin
		emit_nib.last = emit_last;
		case (cw.op)
			clnw_pkg::OP_CONST: begin
				emit_nib.register_select = 1'b0;
				emit_nib.nibble          = cw.konst;
			end
			clnw_pkg::OP_BYTE_HI: begin
				emit_nib.register_select = rs_q;
				emit_nib.nibble          = byte_q[7:4];
			end
			clnw_pkg::OP_BYTE_LO: begin
				emit_nib.register_select = rs_q;
				emit_nib.nibble          = byte_q[3:0];
			end
			clnw_pkg::OP_DIGIT_HI: begin
				emit_nib.register_select = 1'b1;
				emit_nib.nibble          = clnw_pkg::DIGIT_HI_NIB;
			end
			clnw_pkg::OP_DIGIT_LO: begin
				emit_nib.register_select = 1'b1;
				emit_nib.nibble          = digit;
			end
			default: begin
				emit_nib.register_select = 1'b0;
				emit_nib.nibble          = 4'h0;
			end
		endcase
	end

	// double dabble: add 3 to any digit of five or more, then shift
	always_comb begin
		for (int d = 0; d < MAX_DIGITS; d++) begin
			if (bcd_q[4*d +: 4] >= 4'd5) begin
				bcd_adj[4*d +: 4] = bcd_q[4*d +: 4] + 4'd3;
			end else begin
				bcd_adj[4*d +: 4] = bcd_q[4*d +: 4];
			end
		end
	end

	// sequencer: step counter with one conditional back jump
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			upc_q   <= clnw_pkg::UA_INIT;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_take && kind_ok) begin
						state_q <= ST_RUN;
						upc_q   <= entry;
					end
				end
				ST_RUN: begin
					if (step_go) begin
						if (emit_go && emit_last) begin
							state_q <= ST_IDLE;
						end else if (cw.op == clnw_pkg::OP_DIGIT_LO) begin
							upc_q <= cw.target;
						end else begin
							upc_q <= upc_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, loaded on the request beat and worked by the program
	always_ff @(posedge clk) begin
		if (req_take) begin
			byte_q    <= req_byte;
			rs_q      <= (req.kind == clnw_pkg::KIND_DATA);
			num_q     <= req.number_value;
			bcd_q     <= '0;
			bit_cnt_q <= '0;
			dig_idx_q <= lead;
		end else if (state_q == ST_RUN) begin
			if (cw.op == clnw_pkg::OP_DABBLE) begin
				bcd_q     <= {bcd_adj[BCD_W-2:0], num_q[clnw_pkg::NUM_W-1]};
				num_q     <= {num_q[clnw_pkg::NUM_W-2:0], 1'b0};
				bit_cnt_q <= bit_cnt_q + 1'b1;
			end
			if (emit_go && (cw.op == clnw_pkg::OP_DIGIT_LO) && (dig_idx_q != '0)) begin
				dig_idx_q <= dig_idx_q - 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// output register: holds a beat while the far side stalls
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nib_valid_q <= 1'b0;
		end else if (emit_go) begin
			nib_valid_q <= 1'b1;
		end else if (!nib_stall) begin
			nib_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			nib_q <= emit_nib;
		end
	end

	assign nib_valid = nib_valid_q;
	assign nib       = nib_q;

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	`CLNW_ASSERT_NEXT(a_last_ends_run, emit_go && emit_last, state_q == ST_IDLE)
	`CLNW_ASSERT_SAME(a_upc_range, state_q == ST_RUN, upc_q <= clnw_pkg::UA_LAST)
	`CLNW_ASSERT_SAME(a_dig_range, state_q == ST_RUN, {1'b0, dig_idx_q} < (DIG_W + 1)'(MAX_DIGITS))
	`CLNW_ASSERT_NEXT(a_no_overwrite, nib_valid_q && nib_stall && !emit_go, nib_valid_q && $stable(nib_q))

endmodule

### tb/sv/testbench.sv
// self-checking testbench for the character lcd nibble writer
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DIGIT_LIMIT = 10;
	localparam int ITEMS_PER_PHASE = 35;
	// idle time after the last expected nibble, before the next phase starts
	localparam int SETTLE_CYCLES = 40;

	// kinds that the block ignores
	localparam logic [2:0] KIND_SPARE_A = 3'd6;
	localparam logic [2:0] KIND_SPARE_B = 3'd7;

	// power-up sequence: three half commands, then five full commands
	localparam logic [3:0] WAKE_NIBBLES [3] = '{4'h3, 4'h3, 4'h2};
	localparam logic [7:0] SETUP_CMDS [5] = '{8'h28, 8'h0C, 8'h01, 8'h06, 8'h80};

	logic           clk;
	logic           arst_n;
	logic           req_valid;
	logic           req_stall;
	clnw_pkg::req_t req;
	logic           nib_valid;
	logic           nib_stall;
	clnw_pkg::nib_t nib;
	logic           psel;
	logic           penable;
	logic           pwrite;
	logic [2:0]     paddr;
	logic [31:0]    pwdata;
	logic [31:0]    prdata;
	logic           pready;

	// model copy of the line length register
	logic [6:0]     line_length;

	clnw_pkg::req_t pending_reqs[$];
	clnw_pkg::nib_t expected_nibbles[$];
	int             mismatch_count;

	// handshake flags sampled at the rising edge, used by the falling-edge drivers
	bit          req_taken;
	bit          nib_taken;
	int          req_gap;
	int          stall_left;
	bit          req_idle_on;
	bit          nib_idle_on;

	char_lcd_nibble_writer #(
		.MAX_DIGITS(DIGIT_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.nib_valid(nib_valid),
		.nib_stall(nib_stall),
		.nib(nib),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// expected nibble stream of one request, given the current line length
	function automatic void predict_nibbles(input clnw_pkg::req_t r);
		logic [4:0]     seq[$];
		logic [8:0]     bytes_q[$];
		logic [3:0]     digits[$];
		logic [30:0]    rest;
		logic [7:0]     addr;
		clnw_pkg::nib_t n;
		begin
			case (r.kind)
				clnw_pkg::KIND_INIT: begin
					foreach (WAKE_NIBBLES[i]) seq.push_back({1'b0, WAKE_NIBBLES[i]});
					foreach (SETUP_CMDS[i]) bytes_q.push_back({1'b0, SETUP_CMDS[i]});
				end
				clnw_pkg::KIND_HALF:  seq.push_back({1'b0, r.byte_value[7:4]});
				clnw_pkg::KIND_CMD:   bytes_q.push_back({1'b0, r.byte_value});
				clnw_pkg::KIND_DATA:  bytes_q.push_back({1'b1, r.byte_value});
				clnw_pkg::KIND_CURSOR: begin
					case (r.line_number)
						3'd1:    addr = 8'h40;
						3'd2:    addr = 8'h10;
						3'd3:    addr = 8'h50;
						default: addr = 8'h00;
					endcase
					// column only counts when it fits the line
					if (r.column <= {1'b0, line_length}) addr = addr + r.column;
					bytes_q.push_back({1'b0, clnw_pkg::CMD_SET_DDRAM | addr});
				end
				clnw_pkg::KIND_NUMBER: begin
					rest = r.number_value;
					if (rest == 0) digits.push_back(4'd0);
					while (rest != 0 && digits.size() < DIGIT_LIMIT) begin
						digits.push_front(4'(rest % 10));
						rest = rest / 10;
					end
					foreach (digits[i])
						bytes_q.push_back({1'b1, clnw_pkg::DIGIT_HI_NIB, digits[i]});
				end
				default: ;
			endcase
			foreach (bytes_q[i]) begin
				seq.push_back({bytes_q[i][8], bytes_q[i][7:4]});
				seq.push_back({bytes_q[i][8], bytes_q[i][3:0]});
			end
			foreach (seq[i]) begin
				n.register_select = seq[i][4];
				n.nibble = seq[i][3:0];
				n.last = (i == seq.size() - 1);
				expected_nibbles.push_back(n);
			end
		end
	endfunction

	function automatic clnw_pkg::req_t make_req(input logic [2:0] kind, input logic [7:0] b,
			input logic [2:0] line, input logic [7:0] col, input logic [30:0] num);
		clnw_pkg::req_t r;
		begin
			r.kind = kind;
			r.byte_value = b;
			r.line_number = line;
			r.column = col;
			r.number_value = num;
			return r;
		end
	endfunction

	// random request, weighted toward the kinds with interesting content
	function automatic clnw_pkg::req_t random_request();
		clnw_pkg::req_t r;
		int unsigned    pick;
		begin
			r.byte_value = 8'($urandom);
			r.line_number = 3'($urandom_range(0, 7));
			// half the columns sit at the line length boundary or one either side of it
			if ($urandom_range(0, 1) == 1)
				r.column = 8'($urandom);
			else
				r.column = 8'(line_length) + 8'($urandom_range(0, 2)) - 8'd1;
			// spread the magnitude so short and long numbers both show up
			r.number_value = 31'($urandom) >> $urandom_range(0, 30);
			if ($urandom_range(0, 15) == 0) r.number_value = '0;
			if ($urandom_range(0, 7) == 0) r.number_value = 31'($urandom);
			pick = $urandom_range(0, 15);
			if (pick == 0)       r.kind = clnw_pkg::KIND_INIT;
			else if (pick <= 2)  r.kind = clnw_pkg::KIND_HALF;
			else if (pick <= 4)  r.kind = clnw_pkg::KIND_CMD;
			else if (pick <= 7)  r.kind = clnw_pkg::KIND_DATA;
			else if (pick <= 10) r.kind = clnw_pkg::KIND_CURSOR;
			else if (pick <= 14) r.kind = clnw_pkg::KIND_NUMBER;
			else                 r.kind = $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
			return r;
		end
	endfunction

	// apb write of line_length, then read it back
	task automatic write_line_length(input logic [6:0] value);
		begin
			@(negedge clk);
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b1;
			paddr <= clnw_pkg::ADDR_LINE_LENGTH;
			pwdata <= {25'd0, value};
			@(negedge clk);
			penable <= 1'b1;
			@(posedge clk);
			line_length = value;
			@(negedge clk);
			penable <= 1'b0;
			pwrite <= 1'b0;
			@(negedge clk);
			penable <= 1'b1;
			@(posedge clk);
			if (prdata[6:0] !== line_length) begin
				$display("%0t: line_length readback expected %0d, got %0d",
					$time, line_length, prdata[6:0]);
				mismatch_count++;
			end
			@(negedge clk);
			psel <= 1'b0;
			penable <= 1'b0;
		end
	endtask

	// block until every request went in and every nibble came out
	task automatic drain();
		begin
			while (pending_reqs.size() != 0 || req_valid || expected_nibbles.size() != 0)
				@(posedge clk);
			repeat (SETTLE_CYCLES) @(posedge clk);
		end
	endtask

	// sample both handshakes, predict on request beats, check nibble beats
	always @(posedge clk) begin
		clnw_pkg::nib_t want;
		req_taken = arst_n && req_valid && !req_stall;
		nib_taken = arst_n && nib_valid && !nib_stall;
		if (req_taken) predict_nibbles(req);
		if (nib_taken) begin
			if (expected_nibbles.size() == 0) begin
				$display("%0t: nibble beat with nothing expected, got rs=%0b nib=%h last=%0b",
					$time, nib.register_select, nib.nibble, nib.last);
				mismatch_count++;
			end else begin
				want = expected_nibbles.pop_front();
				if (nib.register_select !== want.register_select || nib.nibble !== want.nibble
						|| nib.last !== want.last) begin
					$display("%0t: expected rs=%0b nib=%h last=%0b, got rs=%0b nib=%h last=%0b",
						$time, want.register_select, want.nibble, want.last,
						nib.register_select, nib.nibble, nib.last);
					mismatch_count++;
				end
			end
		end
	end

	// request driver: one beat per pending item, random gap after each
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_valid || req_taken) begin
				if (req_gap > 0) begin
					req_gap--;
					req_valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					req <= pending_reqs.pop_front();
					req_valid <= 1'b1;
					// occasionally flip between gappy and back-to-back stretches
					if ($urandom_range(0, 31) == 0) req_idle_on = !req_idle_on;
					req_gap = req_idle_on ? $urandom_range(0, 3) : 0;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// nibble receiver: random stall after each accepted beat
	always @(negedge clk) begin
		if (arst_n) begin
			if (nib_taken) begin
				if ($urandom_range(0, 31) == 0) nib_idle_on = !nib_idle_on;
				stall_left = nib_idle_on ? $urandom_range(0, 3) : 0;
			end
			if (stall_left > 0) begin
				nib_stall <= 1'b1;
				stall_left--;
			end else begin
				nib_stall <= 1'b0;
			end
		end
	end

	initial begin
		logic [6:0] settings[6];
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		nib_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		line_length = clnw_pkg::LINE_LENGTH_RESET;
		mismatch_count = 0;
		req_gap = 0;
		stall_left = 0;
		req_idle_on = 1'b1;
		nib_idle_on = 1'b1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part at the reset line length of 16
		pending_reqs.push_back(make_req(clnw_pkg::KIND_INIT, 8'h00, 3'd0, 8'd0, 31'd0));
		pending_reqs.push_back(make_req(clnw_pkg::KIND_HALF, 8'h00, 3'd0, 8'd0, 31'd0));
		pending_reqs.push_back(make_req(clnw_pkg::KIND_HALF, 8'hFF, 3'd7, 8'hFF, '1));
		pending_reqs.push_back(make_req(clnw_pkg::KIND_CMD, 8'h00, 3'd0, 8'd0, 31'd0));
		pending_reqs.push_back(make_req(clnw_pkg::KIND_CMD, 8'hFF, 3'd0, 8'd0, 31'd0));
		pending_reqs.push_back(make_req(clnw_pkg::KIND_DATA, 8'h00, 3'd0, 8'd0, 31'd0));
		pending_reqs.push_back(make_req(clnw_pkg::KIND_DATA, 8'hFF, 3'd0, 8'd0, 31'd0));
		// cursor: every line, column at zero, at the limit, past it, and maximal
		pending_reqs.push_back(make_req(clnw_pkg::KIND_CURSOR, 8'h00, 3'd0, 8'd0, 31'd0));
		pending_reqs.push_back(make_req(clnw_pkg::KIND_CURSOR, 8'h00, 3'd1, 8'd16, 31'd0));
		pending_reqs.push_back(make_req(clnw_pkg::KIND_CURSOR, 8'h00, 3'd2, 8'd17, 31'd0));
		pending_reqs.push_back(make_req(clnw_pkg::KIND_CURSOR, 8'h00, 3'd3, 8'd255, 31'd0));
		pending_reqs.push_back(make_req(clnw_pkg::KIND_CURSOR, 8'h00, 3'd3, 8'd15, 31'd0));
		pending_reqs.push_back(make_req(clnw_pkg::KIND_CURSOR, 8'h00, 3'd4, 8'd5, 31'd0));
		pending_reqs.push_back(make_req(clnw_pkg::KIND_CURSOR, 8'h00, 3'd7, 8'd200, 31'd0));
		// numbers: zero, single digit, power of ten, largest values
		pending_reqs.push_back(make_req(clnw_pkg::KIND_NUMBER, 8'h00, 3'd0, 8'd0, 31'd0));
		pending_reqs.push_back(make_req(clnw_pkg::KIND_NUMBER, 8'h00, 3'd0, 8'd0, 31'd9));
		pending_reqs.push_back(make_req(clnw_pkg::KIND_NUMBER, 8'h00, 3'd0, 8'd0, 31'd10));
		pending_reqs.push_back(make_req(clnw_pkg::KIND_NUMBER, 8'h00, 3'd0, 8'd0,
			31'd1000000000));
		pending_reqs.push_back(make_req(clnw_pkg::KIND_NUMBER, 8'h00, 3'd0, 8'd0,
			31'd2147483647));
		// ignored kinds between real ones
		pending_reqs.push_back(make_req(KIND_SPARE_A, 8'hFF, 3'd7, 8'hFF, '1));
		pending_reqs.push_back(make_req(clnw_pkg::KIND_DATA, 8'h41, 3'd0, 8'd0, 31'd0));
		pending_reqs.push_back(make_req(KIND_SPARE_B, 8'h00, 3'd0, 8'd0, 31'd0));
		pending_reqs.push_back(make_req(clnw_pkg::KIND_HALF, 8'h30, 3'd0, 8'd0, 31'd0));
		drain();

		// random phases over several line lengths, zero and the top value included
		settings = '{7'd0, 7'd127, 7'd1, 7'd64, 7'($urandom_range(1, 64)), 7'd16};
		foreach (settings[p]) begin
			write_line_length(settings[p]);
			repeat (ITEMS_PER_PHASE) pending_reqs.push_back(random_request());
			drain();
		end

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// hang guard
	initial begin
		#5ms;
		$display("Mismatches found");
		$finish;
	end

endmodule

### files.f
+incdir+sv
sv/clnw_pkg.sv
sv/char_lcd_nibble_writer.sv
tb/sv/testbench.sv
